// ----- hw/rtl/mcs_pkg.sv -----
package mcs_pkg;

  // channel count and countdown width
  localparam int NUM_CHANNELS = 4;
  localparam int COUNT_BITS   = 16;

  // fixed field widths
  localparam int CMD_BITS   = 2;
  localparam int CH_BITS    = 2;
  localparam int MIN_BITS   = 16;
  localparam int TPM_BITS   = 8;
  localparam int HOLD_BITS  = 16;
  localparam int OUT_BITS   = 4;
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 16;
  localparam int PROD_BITS  = MIN_BITS + TPM_BITS;

  // configuration register indexes and reset values
  localparam logic [CFG_IDX_BITS-1:0] CFG_TICKS_PER_MINUTE = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_ALERT_HOLD_TICKS = 2'd1;
  localparam logic [TPM_BITS-1:0]     TPM_RESET  = 8'd12;
  localparam logic [HOLD_BITS-1:0]    HOLD_RESET = 16'(12 * 2);

  typedef enum logic [CMD_BITS-1:0] {
    CMD_TICK      = 2'd0,
    CMD_SWITCH    = 2'd1,
    CMD_ARM       = 2'd2,
    CMD_INTRUSION = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ACT_NONE = 2'd0,
    ACT_ON   = 2'd1,
    ACT_OFF  = 2'd2
  } act_t;

  // one input word
  typedef struct packed {
    cmd_t                command;
    logic [CH_BITS-1:0]  channel;
    logic                switch_on;
    logic [MIN_BITS-1:0] minutes;
  } item_t;

  // one result word
  typedef struct packed {
    logic [OUT_BITS-1:0] output_bits;
    logic                engine_running;
    logic                alert_enabled;
    logic                alert_raised;
  } res_t;

endpackage

// ----- hw/rtl/mcs_in_reg.sv -----
module mcs_in_reg (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  mcs_pkg::item_t  in_item,
  input  logic            advance,
  output logic            item_vld,
  output mcs_pkg::item_t  item
);

  logic           vld_r;
  mcs_pkg::item_t item_r;

  // hold the input word until the result stage can take it
  assign in_stall = vld_r && !advance;
  assign item_vld = vld_r;
  assign item     = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (!in_stall) begin
      vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      item_r <= in_item;
    end
  end

endmodule

// ----- hw/rtl/mcs_core.sv -----
module mcs_core (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [mcs_pkg::CFG_IDX_BITS-1:0]     cfg_idx,
  input  logic [mcs_pkg::CFG_DATA_BITS-1:0]    cfg_wdata,
  input  logic                                 fire,
  input  mcs_pkg::item_t                       item,
  output mcs_pkg::res_t                        res
);

  // configuration registers
  logic [mcs_pkg::TPM_BITS-1:0]  tpm_r;
  logic [mcs_pkg::HOLD_BITS-1:0] hold_cfg_r;

  // channel and alert state
  logic [mcs_pkg::NUM_CHANNELS-1:0] state_r, state_nxt;
  logic [mcs_pkg::COUNT_BITS-1:0]   count_r   [mcs_pkg::NUM_CHANNELS];
  logic [mcs_pkg::COUNT_BITS-1:0]   count_nxt [mcs_pkg::NUM_CHANNELS];
  mcs_pkg::act_t                    action_r  [mcs_pkg::NUM_CHANNELS];
  mcs_pkg::act_t                    action_nxt[mcs_pkg::NUM_CHANNELS];
  logic [mcs_pkg::HOLD_BITS-1:0]    hold_r, hold_nxt;
  logic                             armed_r, armed_nxt;
  logic                             active_r, active_nxt;

  logic [mcs_pkg::PROD_BITS-1:0]  prod;
  logic [mcs_pkg::COUNT_BITS-1:0] load_count;
  logic                           sat;
  logic                           pending;
  logic                           raised;

  // timer load: minutes times ticks per minute, saturated
  always_comb begin
    prod = item.minutes * tpm_r;
    sat  = (mcs_pkg::COUNT_BITS < mcs_pkg::PROD_BITS) &&
           ((prod >> mcs_pkg::COUNT_BITS) != '0);
    load_count = sat ? '1 : mcs_pkg::COUNT_BITS'(prod);
  end

  // next state for one word
  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    action_nxt = action_r;
    hold_nxt   = hold_r;
    armed_nxt  = armed_r;
    active_nxt = active_r;
    pending    = 1'b0;
    raised     = 1'b0;
    unique case (item.command)
      mcs_pkg::CMD_TICK: begin
        if (active_r) begin
          for (int i = 0; i < mcs_pkg::NUM_CHANNELS; i++) begin
            if (count_r[i] != '0) begin
              count_nxt[i] = count_r[i] - 1'b1;
              pending      = 1'b1;
            end else begin
              // action stays armed and fires again on every tick while the engine runs
              case (action_r[i])
                mcs_pkg::ACT_ON:  state_nxt[i] = 1'b1;
                mcs_pkg::ACT_OFF: state_nxt[i] = 1'b0;
                default: ;
              endcase
            end
          end
          // hold reaching zero re-enables alerts only on the following tick
          if (hold_r != '0) begin
            hold_nxt = hold_r - 1'b1;
            pending  = 1'b1;
          end else begin
            armed_nxt = 1'b1;
          end
          if (!pending) begin
            active_nxt = 1'b0;
          end
        end
      end
      mcs_pkg::CMD_SWITCH: begin
        for (int i = 0; i < mcs_pkg::NUM_CHANNELS; i++) begin
          if (32'(item.channel) == i) begin
            state_nxt[i] = item.switch_on;
          end
        end
      end
      mcs_pkg::CMD_ARM: begin
        for (int i = 0; i < mcs_pkg::NUM_CHANNELS; i++) begin
          if (32'(item.channel) == i) begin
            state_nxt[i]  = !item.switch_on;
            action_nxt[i] = item.switch_on ? mcs_pkg::ACT_ON : mcs_pkg::ACT_OFF;
            count_nxt[i]  = load_count;
            active_nxt    = 1'b1;
          end
        end
      end
      mcs_pkg::CMD_INTRUSION: begin
        if (armed_r) begin
          armed_nxt  = 1'b0;
          hold_nxt   = hold_cfg_r;
          active_nxt = 1'b1;
          raised     = 1'b1;
        end
      end
    endcase
  end

  // result reflects the state after this word
  always_comb begin
    res.output_bits    = mcs_pkg::OUT_BITS'(state_nxt);
    res.engine_running = active_nxt;
    res.alert_enabled  = armed_nxt;
    res.alert_raised   = raised;
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tpm_r      <= mcs_pkg::TPM_RESET;
      hold_cfg_r <= mcs_pkg::HOLD_RESET;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        mcs_pkg::CFG_TICKS_PER_MINUTE: tpm_r <= cfg_wdata[mcs_pkg::TPM_BITS-1:0];
        mcs_pkg::CFG_ALERT_HOLD_TICKS: hold_cfg_r <= cfg_wdata[mcs_pkg::HOLD_BITS-1:0];
        default: ;
      endcase
    end
  end

  // state update
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= '0;
      hold_r   <= '0;
      armed_r  <= 1'b1;
      active_r <= 1'b0;
      for (int i = 0; i < mcs_pkg::NUM_CHANNELS; i++) begin
        count_r[i]  <= '0;
        action_r[i] <= mcs_pkg::ACT_NONE;
      end
    end else if (fire) begin
      state_r  <= state_nxt;
      hold_r   <= hold_nxt;
      armed_r  <= armed_nxt;
      active_r <= active_nxt;
      count_r  <= count_nxt;
      action_r <= action_nxt;
    end
  end

endmodule

// ----- hw/rtl/mcs_out_reg.sv -----
module mcs_out_reg (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           item_vld,
  input  mcs_pkg::res_t  res,
  output logic           advance,
  output logic           out_valid,
  input  logic           out_stall,
  output mcs_pkg::res_t  out_res
);

  logic          vld_r;
  mcs_pkg::res_t res_r;

  // result register takes a new word when empty or being drained
  assign advance   = !vld_r || !out_stall;
  assign out_valid = vld_r;
  assign out_res   = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (advance) begin
      vld_r <= item_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && item_vld) begin
      res_r <= res;
    end
  end

endmodule

// ----- hw/rtl/multichannel_countdown_switch_top.sv -----
// Four-channel countdown switch with intrusion alert hold. Each input word
// (tick, direct switch, timer arm or intrusion) yields exactly one result word
// with the channel bits, engine and alert status after that word. Throughput
// is one word per clock while out_stall is low; each word passes an input
// register, then the result register, with the whole state update (per-channel
// decrement and compare, 16x8 timer multiply with saturation) done in one pass
// between them. Ticks are ignored while the engine is stopped. Configuration
// writes are always ready and should be issued only while no word is in flight.
module multichannel_countdown_switch_top (
  input  logic                                clk,
  input  logic                                rst_n,
  // input channel
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [mcs_pkg::CMD_BITS-1:0]        in_command,
  input  logic [mcs_pkg::CH_BITS-1:0]         in_channel,
  input  logic                                in_switch_on,
  input  logic [mcs_pkg::MIN_BITS-1:0]        in_minutes,
  // result channel
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [mcs_pkg::OUT_BITS-1:0]        out_output_bits,
  output logic                                out_engine_running,
  output logic                                out_alert_enabled,
  output logic                                out_alert_raised,
  // configuration
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [mcs_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  logic [mcs_pkg::CFG_DATA_BITS-1:0]   cfg_data
);

  mcs_pkg::item_t in_item;
  mcs_pkg::item_t item;
  mcs_pkg::res_t  res;
  mcs_pkg::res_t  out_res;
  logic           item_vld;
  logic           advance;

  assign cfg_ready = 1'b1;

  // pack the input word
  assign in_item.command   = mcs_pkg::cmd_t'(in_command);
  assign in_item.channel   = in_channel;
  assign in_item.switch_on = in_switch_on;
  assign in_item.minutes   = in_minutes;

  mcs_in_reg u_in_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .advance  (advance),
    .item_vld (item_vld),
    .item     (item)
  );

  mcs_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_valid),
    .cfg_idx   (cfg_index),
    .cfg_wdata (cfg_data),
    .fire      (item_vld && advance),
    .item      (item),
    .res       (res)
  );

  mcs_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .item_vld  (item_vld),
    .res       (res),
    .advance   (advance),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  // unpack the result word
  assign out_output_bits    = out_res.output_bits;
  assign out_engine_running = out_res.engine_running;
  assign out_alert_enabled  = out_res.alert_enabled;
  assign out_alert_raised   = out_res.alert_raised;

endmodule
